@@ hw/rtl/amx_pkg.sv @@
// shared types, step codes and operand table for the 3x3 matrix inverse
package amx_pkg;

   localparam int NUM_ENT    = 9;
   localparam int ADJ_STEPS  = 18;
   localparam int STEP_W     = 5;
   localparam logic [STEP_W-1:0] LAST_STEP = 5'd23;
   localparam logic [STEP_W-1:0] DET_STEP0 = STEP_W'(ADJ_STEPS);

   typedef logic [STEP_W-1:0] step_type;
   typedef logic [3:0] idx_type;

   typedef struct packed {
      idx_type a;
      idx_type b;
   } opnd_type;

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_RUN  = 3'b010,
      F_PUSH = 3'b100
   } front_state_type;

   typedef enum logic [4:0] {
      B_IDLE = 5'b00001,
      B_LOAD = 5'b00010,
      B_CHK  = 5'b00100,
      B_DIV  = 5'b01000,
      B_DONE = 5'b10000
   } back_state_type;

   // entry pair for adjugate entry m, first or second product of the cofactor
   function automatic opnd_type amx_opnd(input idx_type m, input logic odd);
      opnd_type r;
      r.a = 4'd0;
      r.b = 4'd0;
      unique case (m)
         4'd0: begin r.a = odd ? 4'd5 : 4'd4; r.b = odd ? 4'd7 : 4'd8; end
         4'd1: begin r.a = odd ? 4'd8 : 4'd7; r.b = odd ? 4'd1 : 4'd2; end
         4'd2: begin r.a = odd ? 4'd2 : 4'd1; r.b = odd ? 4'd4 : 4'd5; end
         4'd3: begin r.a = odd ? 4'd3 : 4'd5; r.b = odd ? 4'd8 : 4'd6; end
         4'd4: begin r.a = odd ? 4'd6 : 4'd8; r.b = odd ? 4'd2 : 4'd0; end
         4'd5: begin r.a = odd ? 4'd0 : 4'd2; r.b = odd ? 4'd5 : 4'd3; end
         4'd6: begin r.a = odd ? 4'd4 : 4'd3; r.b = odd ? 4'd6 : 4'd7; end
         4'd7: begin r.a = odd ? 4'd7 : 4'd6; r.b = odd ? 4'd0 : 4'd1; end
         4'd8: begin r.a = odd ? 4'd1 : 4'd0; r.b = odd ? 4'd3 : 4'd4; end
         default: begin r.a = 4'd0; r.b = 4'd0; end
      endcase
      return r;
   endfunction

endpackage

@@ hw/rtl/affine_matrix_inverse_3x3.sv @@
// top level of the 3x3 fixed-point matrix inverse
//
// channel  direction  handshake             payload
// req_     in         req_valid/req_stall   req_a00 .. req_a22
// rsp_     out        rsp_valid/rsp_stall   rsp_inv00 .. rsp_inv22, rsp_singular, rsp_overflowed
//
// front: one multiplier forms 24 products (18 adjugate, 6 determinant) per matrix
// back: nine divider lanes share one shifted divisor, one quotient bit a cycle
// the front can take a new matrix while the back-end divider still works on earlier ones
// a request passes holding register, multiply sequencer, queue, divider and result register
// synchronous active-high reset empties holding register, queue and result register
// a held request and two queued matrices let each side stall on its own
module affine_matrix_inverse_3x3 #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic signed [DATA_WIDTH-1:0] req_a00,
   input  logic signed [DATA_WIDTH-1:0] req_a01,
   input  logic signed [DATA_WIDTH-1:0] req_a02,
   input  logic signed [DATA_WIDTH-1:0] req_a10,
   input  logic signed [DATA_WIDTH-1:0] req_a11,
   input  logic signed [DATA_WIDTH-1:0] req_a12,
   input  logic signed [DATA_WIDTH-1:0] req_a20,
   input  logic signed [DATA_WIDTH-1:0] req_a21,
   input  logic signed [DATA_WIDTH-1:0] req_a22,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic signed [DATA_WIDTH-1:0] rsp_inv00,
   output logic signed [DATA_WIDTH-1:0] rsp_inv01,
   output logic signed [DATA_WIDTH-1:0] rsp_inv02,
   output logic signed [DATA_WIDTH-1:0] rsp_inv10,
   output logic signed [DATA_WIDTH-1:0] rsp_inv11,
   output logic signed [DATA_WIDTH-1:0] rsp_inv12,
   output logic signed [DATA_WIDTH-1:0] rsp_inv20,
   output logic signed [DATA_WIDTH-1:0] rsp_inv21,
   output logic signed [DATA_WIDTH-1:0] rsp_inv22,
   output logic rsp_singular,
   output logic rsp_overflowed
);
   // queue word: nine adjugate entries then the determinant
   localparam int QW = 9*(2*DATA_WIDTH+1) + 3*DATA_WIDTH+3;

   logic signed [DATA_WIDTH-1:0] a_vec [9];
   logic signed [DATA_WIDTH-1:0] inv_vec [9];
   logic [QW-1:0] push_data, pop_data;
   logic q_push, q_full, q_pop, q_valid;

   assign a_vec[0] = req_a00;
   assign a_vec[1] = req_a01;
   assign a_vec[2] = req_a02;
   assign a_vec[3] = req_a10;
   assign a_vec[4] = req_a11;
   assign a_vec[5] = req_a12;
   assign a_vec[6] = req_a20;
   assign a_vec[7] = req_a21;
   assign a_vec[8] = req_a22;

   assign rsp_inv00 = inv_vec[0];
   assign rsp_inv01 = inv_vec[1];
   assign rsp_inv02 = inv_vec[2];
   assign rsp_inv10 = inv_vec[3];
   assign rsp_inv11 = inv_vec[4];
   assign rsp_inv12 = inv_vec[5];
   assign rsp_inv20 = inv_vec[6];
   assign rsp_inv21 = inv_vec[7];
   assign rsp_inv22 = inv_vec[8];

   // cofactor and determinant sequencer
   amx_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .a_in      (a_vec),
      .q_push    (q_push),
      .q_full    (q_full),
      .q_data    (push_data)
   );

   // decoupling queue
   amx_queue #(.WIDTH(QW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_data  (pop_data)
   );

   // divider lanes and result register
   amx_back #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_pop          (q_pop),
      .q_data         (pop_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_inv        (inv_vec),
      .rsp_singular   (rsp_singular),
      .rsp_overflowed (rsp_overflowed)
   );

endmodule

@@ hw/rtl/amx_front.sv @@
// front end: request holding register and multiply sequencer for adjugate and determinant
module amx_front import amx_pkg::*; #(
   parameter int DATA_WIDTH = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic signed [DATA_WIDTH-1:0] a_in [NUM_ENT],
   output logic q_push,
   input  logic q_full,
   output logic [NUM_ENT*(2*DATA_WIDTH+1)+3*DATA_WIDTH+2:0] q_data
);
   localparam int ADJ_W = 2*DATA_WIDTH+1;
   localparam int DET_W = 3*DATA_WIDTH+3;
   localparam int MW    = DATA_WIDTH+1;
   localparam int PW    = 2*MW;

   logic signed [DATA_WIDTH-1:0] hold_ff [NUM_ENT];
   logic signed [DATA_WIDTH-1:0] hold_in [NUM_ENT];
   logic signed [DATA_WIDTH-1:0] ent_ff [NUM_ENT];
   logic signed [DATA_WIDTH-1:0] ent_in [NUM_ENT];
   logic [ADJ_W-1:0] adj_ff [NUM_ENT];
   logic [ADJ_W-1:0] adj_in [NUM_ENT];
   logic [DET_W-1:0] det_ff, det_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   step_type step_ff, step_in, ptag_ff, ptag_in;
   logic hv_ff, hv_in, pval_ff, pval_in;
   front_state_type state_ff, state_in;

   logic accept, start;
   opnd_type sel;
   step_type didx;
   logic [1:0] k;
   idx_type kcol, kadj;
   logic signed [MW-1:0] opa, opb;
   logic [DET_W-1:0] pext;

   assign req_stall = hv_ff;
   assign accept = req_valid & ~hv_ff;
   assign start  = hv_ff & (state_ff == F_IDLE) & ~pval_ff;
   assign q_push = (state_ff == F_PUSH) & ~pval_ff & ~q_full;

   // operand selection
   always_comb begin
      sel  = amx_opnd(step_ff[4:1], step_ff[0]);
      didx = step_ff - DET_STEP0;
      k    = didx[2:1];
      kadj = {2'b00, k};
      unique case (k)
         2'd0:    kcol = 4'd0;
         2'd1:    kcol = 4'd3;
         default: kcol = 4'd6;
      endcase
      if (step_ff < DET_STEP0) begin
         opa = MW'(ent_ff[sel.a]);
         opb = MW'(ent_ff[sel.b]);
      end else begin
         opa = MW'(ent_ff[kcol]);
         opb = didx[0] ? signed'(adj_ff[kadj][ADJ_W-1:DATA_WIDTH])
                       : signed'({1'b0, adj_ff[kadj][DATA_WIDTH-1:0]});
      end
      prod_in = opa * opb;
   end

   always_comb begin
      hold_in  = hold_ff;
      hv_in    = hv_ff;
      ent_in   = ent_ff;
      adj_in   = adj_ff;
      det_in   = det_ff;
      step_in  = step_ff;
      state_in = state_ff;
      pval_in  = (state_ff == F_RUN);
      ptag_in  = step_ff;
      pext     = {{(DET_W-PW){prod_ff[PW-1]}}, prod_ff};
      if (accept) begin
         hv_in   = 1'b1;
         hold_in = a_in;
      end else if (start) begin
         hv_in = 1'b0;
      end
      unique case (state_ff)
         F_IDLE: begin
            if (start) begin
               ent_in   = hold_ff;
               det_in   = '0;
               step_in  = '0;
               state_in = F_RUN;
            end
         end
         F_RUN: begin
            step_in = step_ff + 5'd1;
            if (step_ff == LAST_STEP) state_in = F_PUSH;
         end
         F_PUSH: begin
            if (q_push) state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
      // accumulate the registered product in the cycle after it was formed
      if (pval_ff) begin
         if (ptag_ff < DET_STEP0) begin
            if (ptag_ff[0]) adj_in[ptag_ff[4:1]] = adj_ff[ptag_ff[4:1]] - prod_ff[ADJ_W-1:0];
            else            adj_in[ptag_ff[4:1]] = prod_ff[ADJ_W-1:0];
         end else if (ptag_ff[0] == DET_STEP0[0]) begin
            det_in = det_ff + pext;
         end else begin
            det_in = det_ff + (pext << DATA_WIDTH);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hv_ff    <= 1'b0;
         pval_ff  <= 1'b0;
         state_ff <= F_IDLE;
      end else begin
         hv_ff    <= hv_in;
         pval_ff  <= pval_in;
         state_ff <= state_in;
      end
      hold_ff <= hold_in;
      ent_ff  <= ent_in;
      adj_ff  <= adj_in;
      det_ff  <= det_in;
      step_ff <= step_in;
      ptag_ff <= ptag_in;
      prod_ff <= prod_in;
   end

   always_comb begin
      q_data[NUM_ENT*ADJ_W +: DET_W] = det_ff;
      for (int i = 0; i < NUM_ENT; i++) q_data[i*ADJ_W +: ADJ_W] = adj_ff[i];
   end

endmodule

@@ hw/rtl/amx_queue.sv @@
// two-entry queue between front and back
module amx_queue #(
   parameter int WIDTH = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  logic [WIDTH-1:0] push_data,
   output logic full,
   input  logic pop,
   output logic valid,
   output logic [WIDTH-1:0] pop_data
);
   logic [WIDTH-1:0] mem_ff [2];
   logic wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full     = (cnt_ff == 2'd2);
   assign valid    = (cnt_ff != 2'd0);
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= push_data;
   end

endmodule

@@ hw/rtl/amx_back.sv @@
// back end: nine-lane bit-serial divider, saturation and result register
module amx_back import amx_pkg::*; #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic q_valid,
   output logic q_pop,
   input  logic [NUM_ENT*(2*DATA_WIDTH+1)+3*DATA_WIDTH+2:0] q_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic signed [DATA_WIDTH-1:0] rsp_inv [NUM_ENT],
   output logic rsp_singular,
   output logic rsp_overflowed
);
   localparam int ADJ_W = 2*DATA_WIDTH+1;
   localparam int DET_W = 3*DATA_WIDTH+3;
   // wide enough for the scaled numerator and for the divisor shifted by DATA_WIDTH
   localparam int NUM_W = ADJ_W + 2*FRAC_BITS;
   localparam int BIG_W = DET_W + DATA_WIDTH + 1;
   localparam int CW    = (NUM_W > BIG_W) ? NUM_W : BIG_W;
   localparam int CNT_W = $clog2(DATA_WIDTH);
   localparam logic ONE_SAT = (FRAC_BITS >= DATA_WIDTH-1);
   localparam logic [DATA_WIDTH-1:0] LIM_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic [DATA_WIDTH-1:0] LIM_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};
   localparam logic [DATA_WIDTH-1:0] ONE_VAL =
      ONE_SAT ? LIM_POS : (DATA_WIDTH'(1) << FRAC_BITS);

   back_state_type state_ff, state_in;
   logic [ADJ_W-1:0] adj_ff [NUM_ENT];
   logic [ADJ_W-1:0] adj_in [NUM_ENT];
   logic [CW-1:0] rem_ff [NUM_ENT];
   logic [CW-1:0] rem_in [NUM_ENT];
   logic [DATA_WIDTH-1:0] q_ff [NUM_ENT];
   logic [DATA_WIDTH-1:0] q_in [NUM_ENT];
   logic [NUM_ENT-1:0] big_ff, big_in, neg_ff, neg_in;
   logic [DET_W-1:0] det_ff, det_in, dmag_ff, dmag_in;
   logic [CW-1:0] dsh_ff, dsh_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic sing_ff, sing_in;
   logic rsp_valid_ff, rsp_valid_in, rsp_sing_ff, rsp_sing_in, rsp_ovf_ff, rsp_ovf_in;
   logic [DATA_WIDTH-1:0] rsp_inv_ff [NUM_ENT];
   logic [DATA_WIDTH-1:0] rsp_inv_in [NUM_ENT];

   logic out_free;
   logic [ADJ_W-1:0] amag;
   logic [DATA_WIDTH-1:0] sat_val [NUM_ENT];
   logic [NUM_ENT-1:0] sat_hit;

   assign out_free       = ~rsp_valid_ff | ~rsp_stall;
   assign q_pop          = (state_ff == B_IDLE) & q_valid;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_singular   = rsp_sing_ff;
   assign rsp_overflowed = rsp_ovf_ff;
   always_comb for (int i = 0; i < NUM_ENT; i++) rsp_inv[i] = signed'(rsp_inv_ff[i]);

   // saturation and sign per lane
   always_comb begin
      logic ng;
      logic [DATA_WIDTH-1:0] lim, mag;
      for (int i = 0; i < NUM_ENT; i++) begin
         ng  = neg_ff[i] & (q_ff[i] != '0);
         lim = ng ? LIM_NEG : LIM_POS;
         sat_hit[i] = big_ff[i] | (q_ff[i] > lim);
         mag = sat_hit[i] ? lim : q_ff[i];
         sat_val[i] = ng ? (~mag + DATA_WIDTH'(1)) : mag;
      end
   end

   always_comb begin
      state_in     = state_ff;
      adj_in       = adj_ff;
      det_in       = det_ff;
      rem_in       = rem_ff;
      q_in         = q_ff;
      big_in       = big_ff;
      neg_in       = neg_ff;
      dmag_in      = dmag_ff;
      dsh_in       = dsh_ff;
      cnt_in       = cnt_ff;
      sing_in      = sing_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_sing_in  = rsp_sing_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_inv_in   = rsp_inv_ff;
      amag         = '0;
      unique case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               det_in = q_data[NUM_ENT*ADJ_W +: DET_W];
               for (int i = 0; i < NUM_ENT; i++) adj_in[i] = q_data[i*ADJ_W +: ADJ_W];
               state_in = B_LOAD;
            end
         end
         B_LOAD: begin
            dmag_in = det_ff[DET_W-1] ? (~det_ff + DET_W'(1)) : det_ff;
            for (int i = 0; i < NUM_ENT; i++) begin
               amag = adj_ff[i][ADJ_W-1] ? (~adj_ff[i] + ADJ_W'(1)) : adj_ff[i];
               rem_in[i] = CW'(amag) << (2*FRAC_BITS);
               neg_in[i] = adj_ff[i][ADJ_W-1] ^ det_ff[DET_W-1];
            end
            state_in = B_CHK;
         end
         B_CHK: begin
            sing_in = (dmag_ff == '0);
            for (int i = 0; i < NUM_ENT; i++) begin
               big_in[i] = rem_ff[i] >= (CW'(dmag_ff) << DATA_WIDTH);
               q_in[i]   = '0;
            end
            dsh_in   = CW'(dmag_ff) << (DATA_WIDTH-1);
            cnt_in   = '0;
            state_in = (dmag_ff == '0) ? B_DONE : B_DIV;
         end
         B_DIV: begin
            for (int i = 0; i < NUM_ENT; i++) begin
               if (rem_ff[i] >= dsh_ff) begin
                  rem_in[i] = rem_ff[i] - dsh_ff;
                  q_in[i]   = {q_ff[i][DATA_WIDTH-2:0], 1'b1};
               end else begin
                  q_in[i]   = {q_ff[i][DATA_WIDTH-2:0], 1'b0};
               end
            end
            dsh_in = dsh_ff >> 1;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DATA_WIDTH-1)) state_in = B_DONE;
         end
         B_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_sing_in  = sing_ff;
               if (sing_ff) begin
                  rsp_ovf_in = ONE_SAT;
                  for (int i = 0; i < NUM_ENT; i++)
                     rsp_inv_in[i] = (i % 4 == 0) ? ONE_VAL : '0;
               end else begin
                  rsp_ovf_in = |sat_hit;
                  rsp_inv_in = sat_val;
               end
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      adj_ff     <= adj_in;
      det_ff     <= det_in;
      rem_ff     <= rem_in;
      q_ff       <= q_in;
      big_ff     <= big_in;
      neg_ff     <= neg_in;
      dmag_ff    <= dmag_in;
      dsh_ff     <= dsh_in;
      cnt_ff     <= cnt_in;
      sing_ff    <= sing_in;
      rsp_sing_ff <= rsp_sing_in;
      rsp_ovf_ff <= rsp_ovf_in;
      rsp_inv_ff <= rsp_inv_in;
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_DIV) |-> (cnt_ff <= CNT_W'(DATA_WIDTH-1)))
      else $error("divide counter out of range");
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == B_DONE))
      else $error("result raised outside done state");
   a_sing_ovf: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_sing_ff) |-> (rsp_ovf_ff == ONE_SAT))
      else $error("singular result with wrong overflow flag");

endmodule

@@ tb/affine_matrix_inverse_3x3_tb.sv @@
// testbench for the 3x3 fixed-point matrix inverse: directed and random matrices, self-checking
module affine_matrix_inverse_3x3_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DW = 32;
   localparam int FB = 16;
   localparam logic signed [DW-1:0] ONE = 32'sh0001_0000;

   typedef logic signed [DW-1:0] entry_type;
   typedef entry_type matrix_type [9];

   typedef struct {
      entry_type inv [9];
      logic      singular;
      logic      overflowed;
   } inverse_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   entry_type req_a00 = '0, req_a01 = '0, req_a02 = '0;
   entry_type req_a10 = '0, req_a11 = '0, req_a12 = '0;
   entry_type req_a20 = '0, req_a21 = '0, req_a22 = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   entry_type rsp_inv00, rsp_inv01, rsp_inv02;
   entry_type rsp_inv10, rsp_inv11, rsp_inv12;
   entry_type rsp_inv20, rsp_inv21, rsp_inv22;
   logic rsp_singular, rsp_overflowed;

   // expected inverses in request order
   inverse_type pending_inverses [$];
   int errors = 0;
   int requests_sent = 0;
   int inverses_checked = 0;
   int singular_seen = 0;
   int overflow_seen = 0;
   // idle ceilings for each side, zero gives back-to-back stretches
   int gap_max = 18;
   int stall_max = 18;

   affine_matrix_inverse_3x3 #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_a00(req_a00), .req_a01(req_a01), .req_a02(req_a02),
      .req_a10(req_a10), .req_a11(req_a11), .req_a12(req_a12),
      .req_a20(req_a20), .req_a21(req_a21), .req_a22(req_a22),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_inv00(rsp_inv00), .rsp_inv01(rsp_inv01), .rsp_inv02(rsp_inv02),
      .rsp_inv10(rsp_inv10), .rsp_inv11(rsp_inv11), .rsp_inv12(rsp_inv12),
      .rsp_inv20(rsp_inv20), .rsp_inv21(rsp_inv21), .rsp_inv22(rsp_inv22),
      .rsp_singular(rsp_singular), .rsp_overflowed(rsp_overflowed)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // exact adjugate over determinant, truncated toward zero and saturated
   function automatic inverse_type compute_inverse(input matrix_type m);
      inverse_type r;
      logic signed [255:0] e [9];
      logic signed [255:0] adj [9];
      logic signed [255:0] det;
      logic [255:0] dmag, nmag, quo, lim;
      logic neg;
      int r1, r2, c1, c2;
      for (int k = 0; k < 9; k++) e[k] = m[k];
      // adj(i,j) is the cofactor of entry (j,i), cyclic indexing carries the sign
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            r1 = (j + 1) % 3; r2 = (j + 2) % 3;
            c1 = (i + 1) % 3; c2 = (i + 2) % 3;
            adj[i*3+j] = e[r1*3+c1] * e[r2*3+c2] - e[r1*3+c2] * e[r2*3+c1];
         end
      end
      // expansion along the first column
      det = e[0] * adj[0] + e[3] * adj[1] + e[6] * adj[2];
      r.overflowed = 1'b0;
      if (det == 0) begin
         for (int k = 0; k < 9; k++) r.inv[k] = (k % 4 == 0) ? ONE : '0;
         r.singular = 1'b1;
         return r;
      end
      r.singular = 1'b0;
      dmag = det[255] ? -det : det;
      for (int k = 0; k < 9; k++) begin
         neg = adj[k][255] ^ det[255];
         nmag = adj[k][255] ? -adj[k] : adj[k];
         quo = (nmag << (2 * FB)) / dmag;
         if (quo == 0) neg = 1'b0;
         lim = neg ? (256'd1 << (DW - 1)) : ((256'd1 << (DW - 1)) - 1);
         if (quo > lim) begin
            quo = lim;
            r.overflowed = 1'b1;
         end
         if (neg) quo = -quo;
         r.inv[k] = quo[DW-1:0];
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [DW-1:0] got,
                                  input logic [DW-1:0] want);
      errors++;
      $display("mismatch %0t: %s got %h want %h", $realtime, what, got, want);
   endtask

   // send one matrix after a random gap, the expectation is queued at acceptance
   task automatic send_matrix(input matrix_type m);
      int gap;
      inverse_type want;
      want = compute_inverse(m);
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_a00 <= m[0]; req_a01 <= m[1]; req_a02 <= m[2];
      req_a10 <= m[3]; req_a11 <= m[4]; req_a12 <= m[5];
      req_a20 <= m[6]; req_a21 <= m[7]; req_a22 <= m[8];
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      pending_inverses.push_back(want);
      requests_sent++;
   endtask

   // random entry, arithmetic shift keeps the sign and narrows the magnitude
   function automatic entry_type rand_entry(input int shift);
      entry_type v;
      v = $urandom;
      return v >>> shift;
   endfunction

   // drop the request so nothing is sent again while waiting
   task automatic wait_all_returned();
      req_valid <= 1'b0;
      while (pending_inverses.size() > 0) @(posedge clock);
   endtask

   task automatic test_directed();
      matrix_type m;
      // identity
      m = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};
      send_matrix(m);
      // zero matrix is singular
      m = '{default: '0};
      send_matrix(m);
      // rank two: third row repeats the first
      m = '{ONE, 2*ONE, 3*ONE, 4*ONE, 5*ONE, 6*ONE, ONE, 2*ONE, 3*ONE};
      send_matrix(m);
      // all entries at the extremes, singular
      m = '{default: 32'sh7fff_ffff};
      send_matrix(m);
      m = '{default: 32'sh8000_0000};
      send_matrix(m);
      // extreme diagonal, tiny inverses
      m = '{32'sh7fff_ffff, 0, 0, 0, 32'sh8000_0000, 0, 0, 0, 32'sh7fff_ffff};
      send_matrix(m);
      m = '{32'sh8000_0000, 0, 0, 0, 32'sh8000_0000, 0, 0, 0, 32'sh8000_0000};
      send_matrix(m);
      // one lsb on the diagonal: inverse saturates positive
      m = '{32'sd1, 0, 0, 0, 32'sd1, 0, 0, 0, ONE};
      send_matrix(m);
      // negative lsb: saturates negative
      m = '{-32'sd1, 0, 0, 0, 32'sd1, 0, 0, 0, ONE};
      send_matrix(m);
      // scale by two and a half, translation
      m = '{2*ONE, 0, 10*ONE, 0, ONE/2, -3*ONE, 0, 0, ONE};
      send_matrix(m);
      // quarter turn with translation, negative entries
      m = '{0, -ONE, 5*ONE, ONE, 0, -7*ONE, 0, 0, ONE};
      send_matrix(m);
      // mirror, negative determinant
      m = '{-ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};
      send_matrix(m);
      // shear
      m = '{ONE, ONE, 0, 0, ONE, 0, 0, 0, ONE};
      send_matrix(m);
      // exact inverse of minus one times identity lands on -1.0
      m = '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE};
      send_matrix(m);
      // inverse of 0.5 gives 2.0, of 3 truncates
      m = '{ONE/2, 0, 0, 0, 3*ONE, 0, 0, 0, -3*ONE};
      send_matrix(m);
      // mixed extremes in a full matrix
      m = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sd1, -32'sd1, 32'sh7fff_ffff, 0,
            32'sd1, 32'sh8000_0000, 32'sh7fff_ffff};
      send_matrix(m);
      // mostly alternating bit patterns
      m = '{32'sh5555_5555, 32'shaaaa_aaaa, 32'sh0f0f_0f0f, 32'shf0f0_f0f0,
            32'sh3333_3333, 32'shcccc_cccc, 32'sh1234_5678, 32'sh8765_4321, 32'sh5a5a_a5a5};
      send_matrix(m);
      // zero column makes it singular
      m = '{0, ONE, 2*ONE, 0, 3*ONE, ONE, 0, -ONE, ONE};
      send_matrix(m);
   endtask

   task automatic test_affine_random(input int count);
      matrix_type m;
      for (int n = 0; n < count; n++) begin
         for (int k = 0; k < 6; k++) m[k] = rand_entry($urandom_range(4, 14));
         m[6] = '0; m[7] = '0; m[8] = ONE;
         send_matrix(m);
      end
   endtask

   task automatic test_full_random(input int count);
      matrix_type m;
      for (int n = 0; n < count; n++) begin
         for (int k = 0; k < 9; k++) m[k] = rand_entry($urandom_range(0, 31));
         send_matrix(m);
      end
   endtask

   // rows or columns made dependent, with random content
   task automatic test_singular_random(input int count);
      matrix_type m;
      int kind;
      for (int n = 0; n < count; n++) begin
         for (int k = 0; k < 9; k++) m[k] = rand_entry($urandom_range(2, 20));
         kind = $urandom_range(0, 3);
         case (kind)
            0: for (int c = 0; c < 3; c++) m[6+c] = m[c];
            1: for (int c = 0; c < 3; c++) m[3+c] = m[c] + m[6+c];
            2: for (int r = 0; r < 3; r++) m[r*3+1] = '0;
            default: for (int r = 0; r < 3; r++) m[r*3+2] = -m[r*3];
         endcase
         send_matrix(m);
      end
   endtask

   // pause the sender until everything has come back, then continue
   task automatic test_drain_pause();
      test_full_random(6);
      wait_all_returned();
      test_affine_random(6);
   endtask

   // back-to-back on both sides
   task automatic test_no_idling();
      gap_max = 0;
      stall_max = 0;
      test_affine_random(40);
      test_full_random(40);
      gap_max = 18;
      stall_max = 18;
   endtask

   // receiver: random stall before each result, held until one is taken
   initial begin
      int n;
      @(negedge reset);
      forever begin
         n = $urandom_range(0, stall_max);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   // result checker against the oldest expectation
   initial begin
      inverse_type want;
      entry_type got [9];
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got = '{rsp_inv00, rsp_inv01, rsp_inv02, rsp_inv10, rsp_inv11,
                    rsp_inv12, rsp_inv20, rsp_inv21, rsp_inv22};
            if (pending_inverses.size() == 0) begin
               report_mismatch("unexpected result", '0, '0);
            end else begin
               want = pending_inverses.pop_front();
               for (int k = 0; k < 9; k++)
                  if (got[k] !== want.inv[k])
                     report_mismatch($sformatf("inv%0d%0d", k / 3, k % 3), got[k], want.inv[k]);
               if (rsp_singular !== want.singular)
                  report_mismatch("singular", DW'(rsp_singular), DW'(want.singular));
               if (rsp_overflowed !== want.overflowed)
                  report_mismatch("overflowed", DW'(rsp_overflowed), DW'(want.overflowed));
               inverses_checked++;
               if (want.singular) singular_seen++;
               if (want.overflowed) overflow_seen++;
            end
         end
      end
   end

   // watchdog
   initial begin
      #20ms;
      $display("timeout with %0d results outstanding", pending_inverses.size());
      $display("simulation failed");
      $finish;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_drain_pause();
      test_affine_random(400);
      test_no_idling();
      test_full_random(400);
      test_singular_random(200);
      @(posedge clock);
      wait_all_returned();
      repeat (100) @(posedge clock);
      $display("sent %0d matrices, checked %0d inverses", requests_sent, inverses_checked);
      $display("%0d singular, %0d saturated, %0d mismatches",
               singular_seen, overflow_seen, errors);
      if (errors == 0 && pending_inverses.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

@@ affine_matrix_inverse_3x3.f @@
hw/rtl/amx_pkg.sv
hw/rtl/amx_front.sv
hw/rtl/amx_queue.sv
hw/rtl/amx_back.sv
hw/rtl/affine_matrix_inverse_3x3.sv
tb/affine_matrix_inverse_3x3_tb.sv
